@@ src/booth_radix2_signed_multiplier_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_MACROS_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_MACROS_SVH

// Checked at every rising clock edge, held off while reset is asserted.
`define BRSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BRSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/brsm_pkg.sv @@
package brsm_pkg;

  // Width of the product field on the result channel.
  localparam int PRODUCT_W = 32;

  // Booth recoding pair {multiplier LSB, previous bit}.
  typedef enum logic [1:0] {
    PAIR_HOLD_ZERO = 2'b00,
    PAIR_ADD       = 2'b01,
    PAIR_SUB       = 2'b10,
    PAIR_HOLD_ONE  = 2'b11
  } booth_pair_t;

endpackage

@@ src/brsm_cell.sv @@
module brsm_cell #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH:0]   up_acc,
  input  logic [WIDTH-1:0] up_q,
  input  logic             up_prev,
  input  logic [WIDTH:0]   up_mcand,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH:0]   dn_acc,
  output logic [WIDTH-1:0] dn_q,
  output logic             dn_prev,
  output logic [WIDTH:0]   dn_mcand
);

  logic                 valid_r;
  logic [WIDTH:0]       acc_r;
  logic [WIDTH-1:0]     q_r;
  logic                 prev_r;
  logic [WIDTH:0]       mcand_r;
  logic [WIDTH:0]       acc_sum;
  logic [WIDTH:0]       acc_nxt;
  logic [WIDTH-1:0]     q_nxt;
  brsm_pkg::booth_pair_t pair;

  // The cell takes a new beat when it is empty or its content moves on.
  assign up_ready = !valid_r || dn_ready;

  // One Booth step: add or subtract the multiplicand, then shift A:Q right.
  always_comb begin
    pair = brsm_pkg::booth_pair_t'({up_q[0], up_prev});
    unique case (pair)
      brsm_pkg::PAIR_ADD:       acc_sum = up_acc + up_mcand;
      brsm_pkg::PAIR_SUB:       acc_sum = up_acc - up_mcand;
      brsm_pkg::PAIR_HOLD_ZERO: acc_sum = up_acc;
      brsm_pkg::PAIR_HOLD_ONE:  acc_sum = up_acc;
    endcase
    acc_nxt = {acc_sum[WIDTH], acc_sum[WIDTH:1]};
    q_nxt   = {acc_sum[0], up_q[WIDTH-1:1]};
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Step state, loaded whenever a beat enters.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      acc_r   <= acc_nxt;
      q_r     <= q_nxt;
      prev_r  <= up_q[0];
      mcand_r <= up_mcand;
    end
  end

  assign dn_valid = valid_r;
  assign dn_acc   = acc_r;
  assign dn_q     = q_r;
  assign dn_prev  = prev_r;
  assign dn_mcand = mcand_r;

endmodule

@@ src/booth_radix2_signed_multiplier.sv @@
// An accepted input beat passes through the WIDTH cells in order to its result (16 by default).
// One operand pair is taken per cycle while in_stall is low; each of the WIDTH cells does one Booth step.
// A stalled result holds only the cells behind it that are full; empty cells still fill.
// Reset (rst_n low, synchronous) clears the cell valid flags; data registers are not reset.
module booth_radix2_signed_multiplier #(
  parameter int WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [WIDTH-1:0]              in_multiplicand,
  input  logic signed [WIDTH-1:0]              in_multiplier,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [brsm_pkg::PRODUCT_W-1:0] out_product
);

  localparam int ProdW = 2 * WIDTH;

  logic             valid_c [0:WIDTH];
  logic             ready_c [0:WIDTH];
  logic [WIDTH:0]   acc_c   [0:WIDTH];
  logic [WIDTH-1:0] q_c     [0:WIDTH];
  logic             prev_c  [0:WIDTH];
  logic [WIDTH:0]   mcand_c [0:WIDTH];
  logic [ProdW-1:0] product_full;

  // Head of the chain: accumulator and previous bit start at zero.
  assign valid_c[0] = in_valid;
  assign in_stall   = !ready_c[0];
  assign acc_c[0]   = '0;
  assign q_c[0]     = in_multiplier;
  assign prev_c[0]  = 1'b0;
  assign mcand_c[0] = {in_multiplicand[WIDTH-1], in_multiplicand};

  // One cell per Booth step.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    brsm_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_c[i]),
      .up_ready (ready_c[i]),
      .up_acc   (acc_c[i]),
      .up_q     (q_c[i]),
      .up_prev  (prev_c[i]),
      .up_mcand (mcand_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_ready (ready_c[i+1]),
      .dn_acc   (acc_c[i+1]),
      .dn_q     (q_c[i+1]),
      .dn_prev  (prev_c[i+1]),
      .dn_mcand (mcand_c[i+1])
    );
  end

  // The last cell doubles as the output register.
  assign out_valid      = valid_c[WIDTH];
  assign ready_c[WIDTH] = !out_stall;
  assign product_full   = {acc_c[WIDTH][WIDTH-1:0], q_c[WIDTH]};

  // Fit the 2*WIDTH-bit product to the result field: truncate or zero-fill.
  if (ProdW >= brsm_pkg::PRODUCT_W) begin : g_trunc
    assign out_product = product_full[brsm_pkg::PRODUCT_W-1:0];
  end else begin : g_fill
    assign out_product = {{(brsm_pkg::PRODUCT_W - ProdW){1'b0}}, product_full};
  end

endmodule

@@ src/brsm_checker.sv @@
`include "booth_radix2_signed_multiplier_macros.svh"

module brsm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [brsm_pkg::PRODUCT_W-1:0] out_product
);

  // A result beat is offered and held back in this cycle.
  logic out_held;
  assign out_held = out_valid && out_stall;

  // A stalled result beat stays offered.
  `BRSM_ASSERT(a_out_valid_holds, out_held |=> out_valid, "result beat dropped")

  // A stalled result beat keeps its value.
  `BRSM_ASSERT(a_out_data_holds, out_held |=> $stable(out_product), "result changed while stalled")

  // The input side only stalls when the whole chain is full behind a stalled result.
  `BRSM_ASSERT(a_stall_needs_full, in_stall |-> out_held, "input stalled with room in the chain")

  // Reset empties the chain.
  `BRSM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind booth_radix2_signed_multiplier brsm_checker u_brsm_checker (.*);
